// ===== rtl/cai_pkg.sv =====
// ----------------------------------------------------------------------------
// cai_pkg: shared types for the checked 64-bit integer ALU
// Beat structs, operation and status codes, and the pipeline word.
// ----------------------------------------------------------------------------
package cai_pkg;

   localparam int unsigned DataWidth = 64;
   localparam int unsigned CellCount = DataWidth;
   localparam int unsigned Latency   = CellCount + 2;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_DIV_ZERO = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]                  op_code;
      logic signed [DataWidth-1:0] left_operand;
      logic signed [DataWidth-1:0] right_operand;
   } req_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] result_value;
      logic [1:0]                  status;
   } rsp_type;

   typedef struct packed {
      logic                     valid;
      op_type                   op;
      logic                     neg;
      status_type               status;
      logic [DataWidth-1:0]     sum;
      logic [DataWidth-1:0]     ua;
      logic [DataWidth-1:0]     ub;
      logic [2*DataWidth-1:0]   acc;
   } stage_type;

endpackage

// ===== rtl/cai_prep.sv =====
// ----------------------------------------------------------------------------
// cai_prep: operand preparation stage
// Takes magnitudes, handles add and subtract, and flags division errors.
// ----------------------------------------------------------------------------
module cai_prep
   import cai_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  req_type   req,
   output stage_type stage_out
);

   stage_type stage_ff, stage_in;

   logic [DataWidth-1:0] a, b, sum_add, sum_sub;
   logic                 a_neg, b_neg;

   always_comb begin
      a       = req.left_operand;
      b       = req.right_operand;
      a_neg   = a[DataWidth-1];
      b_neg   = b[DataWidth-1];
      sum_add = a + b;
      sum_sub = a - b;
      stage_in        = '0;
      stage_in.valid  = start;
      stage_in.op     = op_type'(req.op_code);
      stage_in.neg    = a_neg ^ b_neg;
      stage_in.status = ST_OK;
      stage_in.ua     = a_neg ? (~a + 1'b1) : a;
      stage_in.ub     = b_neg ? (~b + 1'b1) : b;
      unique case (op_type'(req.op_code))
         OP_ADD: begin
            stage_in.sum = sum_add;
            if (a_neg == b_neg && sum_add[DataWidth-1] != a_neg) begin
               stage_in.status = ST_OVERFLOW;
            end
         end
         OP_SUB: begin
            stage_in.sum = sum_sub;
            if (a_neg != b_neg && sum_sub[DataWidth-1] != a_neg) begin
               stage_in.status = ST_OVERFLOW;
            end
         end
         OP_MUL: begin
            stage_in.acc = '0;
         end
         OP_DIV: begin
            stage_in.acc = {{DataWidth{1'b0}}, stage_in.ua};
            if (b == '0) begin
               stage_in.status = ST_DIV_ZERO;
            end else if (a == {1'b1, {(DataWidth-1){1'b0}}} && b == '1) begin
               stage_in.status = ST_OVERFLOW;
            end
         end
         default: stage_in.status = ST_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.op     <= stage_in.op;
      stage_ff.neg    <= stage_in.neg;
      stage_ff.status <= stage_in.status;
      stage_ff.sum    <= stage_in.sum;
      stage_ff.ua     <= stage_in.ua;
      stage_ff.ub     <= stage_in.ub;
      stage_ff.acc    <= stage_in.acc;
   end

   assign stage_out = stage_ff;

endmodule

// ===== rtl/cai_cell.sv =====
// ----------------------------------------------------------------------------
// cai_cell: one step of the multiply and divide chain
// Adds one partial product, or retires one quotient bit by restoring division.
// ----------------------------------------------------------------------------
module cai_cell
   import cai_pkg::*;
#(
   parameter int unsigned STEP = 0
)
(
   input  logic      clock,
   input  logic      reset,
   input  stage_type stage_in_p,
   output stage_type stage_out
);

   localparam int unsigned BitIndex = STEP % DataWidth;

   stage_type            stage_ff, stage_in;
   logic [2*DataWidth:0]   shifted;
   logic [DataWidth:0]     top, diff;
   logic [2*DataWidth-1:0] addend;

   always_comb begin
      stage_in = stage_in_p;
      addend   = {{DataWidth{1'b0}}, stage_in_p.ua} << BitIndex;
      shifted  = {stage_in_p.acc, 1'b0};
      top      = shifted[2*DataWidth:DataWidth];
      diff     = top - {1'b0, stage_in_p.ub};
      if (stage_in_p.op == OP_MUL) begin
         if (stage_in_p.ub[BitIndex]) begin
            stage_in.acc = stage_in_p.acc + addend;
         end
      end else if (stage_in_p.op == OP_DIV) begin
         if (top >= {1'b0, stage_in_p.ub}) begin
            stage_in.acc = {diff[DataWidth-1:0], shifted[DataWidth-1:1], 1'b1};
         end else begin
            stage_in.acc = shifted[2*DataWidth-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.op     <= stage_in.op;
      stage_ff.neg    <= stage_in.neg;
      stage_ff.status <= stage_in.status;
      stage_ff.sum    <= stage_in.sum;
      stage_ff.ua     <= stage_in.ua;
      stage_ff.ub     <= stage_in.ub;
      stage_ff.acc    <= stage_in.acc;
   end

   assign stage_out = stage_ff;

endmodule

// ===== rtl/cai_finish.sv =====
// ----------------------------------------------------------------------------
// cai_finish: result stage
// Applies signs, multiply overflow and floor correction, and zeroes errors.
// ----------------------------------------------------------------------------
module cai_finish
   import cai_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  stage_type stage_in_p,
   output logic      rsp_valid,
   output rsp_type   rsp
);

   logic                 valid_ff;
   rsp_type              rsp_ff, rsp_in;
   logic [DataWidth-1:0] hi, lo, value;
   status_type           status;
   logic [DataWidth-1:0] sign_bit;

   always_comb begin
      sign_bit = {1'b1, {(DataWidth-1){1'b0}}};
      hi       = stage_in_p.acc[2*DataWidth-1:DataWidth];
      lo       = stage_in_p.acc[DataWidth-1:0];
      status   = stage_in_p.status;
      value    = stage_in_p.sum;
      if (stage_in_p.op == OP_MUL) begin
         if (hi != '0 || lo > sign_bit || (!stage_in_p.neg && lo == sign_bit)) begin
            status = ST_OVERFLOW;
         end
         value = stage_in_p.neg ? (~lo + 1'b1) : lo;
      end else if (stage_in_p.op == OP_DIV) begin
         if (!stage_in_p.neg) begin
            value = lo;
         end else if (hi != '0) begin
            value = ~lo;
         end else begin
            value = ~lo + 1'b1;
         end
      end
      rsp_in.status       = status;
      rsp_in.result_value = (status == ST_OK) ? value : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stage_in_p.valid;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== rtl/checked_int64_alu_core.sv =====
// ----------------------------------------------------------------------------
// checked_int64_alu_core: pipelined 64-bit signed ALU with error status
// Add, subtract, multiply and floor divide with overflow and zero-divisor flags.
// ----------------------------------------------------------------------------
// Usage:
// A request beat is taken at each rising edge where start is high and busy is
// low. busy is always low, so a new beat may enter in every cycle.
// Each request gives exactly one response beat, shown for one cycle with
// rsp_valid high. Responses leave in request order. A beat passes through
// one prep stage, a chain of 64 cells and one result stage; each cell adds
// one partial product of a multiply or retires one quotient bit of a divide.
// Throughput is one beat per cycle for every operation.
// The receiver cannot stall the response; it must take each beat when shown.
// A synchronous reset clears all valid flags, dropping beats in flight.
// Status is 0 for ok, 1 for overflow and 2 for a zero divisor; any error
// forces the result to zero.
// ----------------------------------------------------------------------------
module checked_int64_alu_core
   import cai_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_beat,
   output logic    rsp_valid,
   output rsp_type rsp_beat
);

   stage_type chain [CellCount+1];

   assign busy = 1'b0;

   cai_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req_beat),
      .stage_out (chain[0])
   );

   for (genvar k = 0; k < CellCount; k++) begin : g_cell
      cai_cell #(
         .STEP (k)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .stage_in_p (chain[k]),
         .stage_out  (chain[k+1])
      );
   end

   cai_finish u_finish (
      .clock      (clock),
      .reset      (reset),
      .stage_in_p (chain[CellCount]),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp_beat)
   );

endmodule

// ===== rtl/cai_checker.sv =====
// ----------------------------------------------------------------------------
// cai_checker: port-level checks for the checked 64-bit ALU
// Watches busy, the response status codes and the zeroed error results.
// ----------------------------------------------------------------------------
module cai_checker
   import cai_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp
);

   a_never_busy : assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("The core stalled a request.");

   a_status_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.status == ST_OK || rsp.status == ST_OVERFLOW ||
                     rsp.status == ST_DIV_ZERO))
      else $error("A response carried an unknown status.");

   a_error_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.status != ST_OK) |-> rsp.result_value == '0)
      else $error("A failed response carried a nonzero result.");

endmodule

bind checked_int64_alu_core cai_checker u_cai_checker (
   .clock     (clock),
   .reset     (reset),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp       (rsp_beat)
);

// ===== test/checked_int64_alu_core_tb.sv =====
// ----------------------------------------------------------------------------
// checked_int64_alu_core_tb: self-checking bench for the checked 64-bit ALU
// Drives add, subtract, multiply and floor divide beats with random gaps and
// compares every response beat, in order, against a behavioral prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module checked_int64_alu_core_tb;
   import cai_pkg::*;

   localparam logic [63:0] MinVal = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MaxVal = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam int unsigned WatchLimit = 2000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req;
   logic    rsp_valid;
   rsp_type rsp;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int      mismatches;
   int      stall_left;
   int      watch_count;
   int      quiet_tail;
   bit      stim_done;
   int      op_seen[4];
   int      status_seen[3];

   checked_int64_alu_core u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_beat(req), .rsp_valid(rsp_valid), .rsp_beat(rsp)
   );

   function automatic logic [63:0] abs64(logic [63:0] v);
      return v[63] ? -v : v;
   endfunction

   function automatic rsp_type compute_alu(req_type r);
      logic [63:0]  a, b, res, q, rm;
      logic [127:0] prod;
      logic         neg;
      status_type   st;
      rsp_type      o;
      a = r.left_operand;
      b = r.right_operand;
      res = '0;
      st = ST_OK;
      case (op_type'(r.op_code))
         OP_ADD: begin
            res = a + b;
            if (a[63] == b[63] && res[63] != a[63]) st = ST_OVERFLOW;
         end
         OP_SUB: begin
            res = a - b;
            if (a[63] != b[63] && res[63] != a[63]) st = ST_OVERFLOW;
         end
         OP_MUL: begin
            prod = {64'd0, abs64(a)} * {64'd0, abs64(b)};
            neg = a[63] != b[63];
            if (prod[127:64] != 0 || prod[63:0] > MinVal || (!neg && prod[63:0] == MinVal))
               st = ST_OVERFLOW;
            else
               res = neg ? -prod[63:0] : prod[63:0];
         end
         default: begin
            if (b == 0) begin
               st = ST_DIV_ZERO;
            end else if (a == MinVal && b == '1) begin
               st = ST_OVERFLOW;
            end else begin
               q = abs64(a) / abs64(b);
               rm = abs64(a) % abs64(b);
               if (a[63] != b[63]) begin
                  if (rm != 0) q = q + 1;
                  res = -q;
               end else begin
                  res = q;
               end
            end
         end
      endcase
      if (st != ST_OK) res = '0;
      o.result_value = res;
      o.status = st;
      return o;
   endfunction

   function automatic logic [63:0] rand_operand();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0: v = MinVal;
         1: v = MaxVal;
         2: v = 64'(int'($urandom_range(0, 20)) - 10);
         3: v = v >>> $urandom_range(1, 63);
         4: v = {{32{v[31]}}, v[31:0]};
         default: ;
      endcase
      return v;
   endfunction

   task automatic push_req(op_type op, logic [63:0] a, logic [63:0] b);
      req_type r;
      r.op_code = op;
      r.left_operand = a;
      r.right_operand = b;
      pending_reqs = {pending_reqs, r};
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      logic [63:0] edge_vals[6];
      edge_vals = '{MinVal, MaxVal, 64'd0, 64'd1, '1, 64'd7};
      reset = 1'b1;
      stim_done = 1'b0;
      foreach (edge_vals[i])
         push_req(OP_ADD, edge_vals[i], edge_vals[(i + 1) % 6]);
      push_req(OP_SUB, MinVal, 64'd1);
      push_req(OP_SUB, MaxVal, '1);
      push_req(OP_SUB, 64'd5, 64'd9);
      push_req(OP_MUL, MinVal, '1);
      push_req(OP_MUL, MinVal, 64'd1);
      push_req(OP_MUL, 64'h1_0000_0000, 64'h8000_0000);
      push_req(OP_MUL, 64'h1_0000_0000, -64'h8000_0000);
      push_req(OP_MUL, MaxVal, MaxVal);
      push_req(OP_DIV, 64'd12, 64'd0);
      push_req(OP_DIV, MinVal, '1);
      push_req(OP_DIV, -64'd7, 64'd2);
      push_req(OP_DIV, 64'd7, -64'd2);
      push_req(OP_DIV, -64'd8, 64'd2);
      push_req(OP_DIV, -64'd7, -64'd2);
      push_req(OP_DIV, MinVal, 64'd1);
      push_req(OP_DIV, MaxVal, MinVal);
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      for (int n = 0; n < 1900; n++) begin
         logic [63:0] a, b;
         a = rand_operand();
         b = (n % 50 == 0) ? 64'd0 : rand_operand();
         push_req(op_type'($urandom_range(0, 3)), a, b);
      end
      stim_done = 1'b1;
   end

   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req <= '0;
         stall_left <= 0;
      end else if (start && busy) begin
      end else if (stall_left > 0) begin
         start <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (pending_reqs.size() > 0 && pending_reqs.size() > 300
                   && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         stall_left <= $urandom_range(0, 2);
      end else if (pending_reqs.size() > 0) begin
         start <= 1'b1;
         req <= pending_reqs.pop_front();
      end else begin
         start <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         mismatches <= 0;
         watch_count <= 0;
         quiet_tail <= 0;
      end else begin
         if (start && !busy) begin
            expected_rsps = {expected_rsps, compute_alu(req)};
            op_seen[req.op_code] = op_seen[req.op_code] + 1;
         end
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               if (mismatches < 10) $display("Unexpected response beat: %h", rsp);
               mismatches <= mismatches + 1;
            end else begin
               rsp_type exp_rsp;
               exp_rsp = expected_rsps.pop_front();
               if (exp_rsp.status < 3) status_seen[exp_rsp.status]++;
               if (rsp.result_value !== exp_rsp.result_value
                   || rsp.status !== exp_rsp.status) begin
                  if (mismatches < 10)
                     $display("Mismatch: expected value %h status %0d, got value %h status %0d",
                              exp_rsp.result_value, exp_rsp.status,
                              rsp.result_value, rsp.status);
                  mismatches <= mismatches + 1;
               end
            end
         end
         watch_count <= ((start && !busy) || rsp_valid) ? 0 : watch_count + 1;
         if (stim_done && pending_reqs.size() == 0 && !start && expected_rsps.size() == 0)
            quiet_tail <= quiet_tail + 1;
         else
            quiet_tail <= 0;
         if (quiet_tail == Latency + 10) begin
            $display("Covered %0d add, %0d sub, %0d mul, %0d div beats;",
                     op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
            $display("statuses ok %0d, overflow %0d, divide by zero %0d.",
                     status_seen[0], status_seen[1], status_seen[2]);
            if (mismatches == 0)
               $display("SUCCESS");
            else
               $display("FAILURE");
            $finish;
         end else if (watch_count >= WatchLimit) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

endmodule

// ===== files.f =====
rtl/cai_pkg.sv
rtl/cai_prep.sv
rtl/cai_cell.sv
rtl/cai_finish.sv
rtl/checked_int64_alu_core.sv
rtl/cai_checker.sv
test/checked_int64_alu_core_tb.sv
